>>> hw/rtl/ght_pkg.sv
// shared types and constants for the generational handle table
// no dependencies; imported by ght_table, generational_handle_table_top, handle_table_check and tb
package ght_pkg;

    localparam int SLOTS        = 16;
    localparam int SLOT_W       = 4;
    localparam int COUNT_W      = 5;
    localparam int SERIAL_W     = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int MODE_W       = 2;

    localparam logic [MODE_W-1:0] MODE_MINT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [SLOT_W-1:0]       slot;
        logic [SERIAL_W-1:0]     serial;
        logic [PAYLOAD_BITS-1:0] payload;
    } op_t;

    typedef struct packed {
        logic                    ok;
        logic [SLOT_W-1:0]       slot;
        logic [SERIAL_W-1:0]     serial;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [COUNT_W-1:0]      used;
    } res_t;

endpackage

>>> hw/rtl/ght_table.sv
// slot storage, occupancy bits, serial counter and the per-operation result logic
// depends on ght_pkg
module ght_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          commit,
    input  ght_pkg::op_t                  op,
    input  logic [ght_pkg::COUNT_W-1:0]   active,
    output ght_pkg::res_t                 res
);
    import ght_pkg::*;

    logic [SLOTS-1:0]        occ_reg;
    logic [SLOTS-1:0]        occ_next;
    logic [PAYLOAD_BITS-1:0] payload_mem [SLOTS];
    logic [SERIAL_W-1:0]     serial_mem [SLOTS];
    logic [SERIAL_W-1:0]     next_serial_reg;
    logic [SERIAL_W-1:0]     next_serial_next;
    logic [COUNT_W-1:0]      used_reg;
    logic [COUNT_W-1:0]      used_next;

    logic [COUNT_W-1:0]      eff;
    logic                    in_range;
    logic                    live;
    logic [SLOTS-1:0]        free;
    logic                    found;
    logic [SLOT_W-1:0]       free_idx;
    logic [SERIAL_W-1:0]     serial_inc;
    logic                    do_mint;
    logic                    do_release;

    assign eff      = (active > COUNT_W'(SLOTS)) ? COUNT_W'(SLOTS) : active;
    assign in_range = ({1'b0, op.slot} < eff);
    assign live     = (op.serial != '0) && in_range && occ_reg[op.slot]
                      && (serial_mem[op.slot] == op.serial);

    // lowest free slot below the active count
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            free[i] = !occ_reg[i] && (COUNT_W'(i) < eff);
            if (free[i])
            begin
                found    = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign serial_inc = next_serial_reg + SERIAL_W'(1);

    always_comb
    begin
        do_mint     = 1'b0;
        do_release  = 1'b0;
        res.ok      = 1'b0;
        res.slot    = '0;
        res.serial  = '0;
        res.payload = '0;
        res.used    = used_reg;
        unique case (op.mode)
            MODE_MINT:
            begin
                if (op.payload != '0 && found)
                begin
                    do_mint    = 1'b1;
                    res.ok     = 1'b1;
                    res.slot   = free_idx;
                    res.serial = next_serial_reg;
                    res.used   = used_reg + COUNT_W'(1);
                end
            end
            MODE_RELEASE:
            begin
                if (live)
                begin
                    do_release = 1'b1;
                    res.ok     = 1'b1;
                    res.used   = used_reg - COUNT_W'(1);
                end
            end
            MODE_LOOKUP:
            begin
                if (live)
                begin
                    res.ok      = 1'b1;
                    res.payload = payload_mem[op.slot];
                end
            end
            default:
            begin
                res.ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        occ_next         = occ_reg;
        used_next        = used_reg;
        next_serial_next = next_serial_reg;
        if (commit && do_mint)
        begin
            occ_next[free_idx] = 1'b1;
            used_next          = used_reg + COUNT_W'(1);
            // wrap skips zero
            next_serial_next   = (serial_inc == '0) ? SERIAL_W'(1) : serial_inc;
        end
        else if (commit && do_release)
        begin
            occ_next[op.slot] = 1'b0;
            used_next         = used_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg         <= '0;
            used_reg        <= '0;
            next_serial_reg <= SERIAL_W'(1);
        end
        else
        begin
            occ_reg         <= occ_next;
            used_reg        <= used_next;
            next_serial_reg <= next_serial_next;
        end
    end

    // entries are only read while their occupancy bit is set
    always_ff @(posedge clk)
    begin
        if (commit && do_mint)
        begin
            payload_mem[free_idx] <= op.payload;
            serial_mem[free_idx]  <= next_serial_reg;
        end
    end

endmodule

>>> hw/rtl/generational_handle_table_top.sv
// Generational handle table: mint, release and look up (slot, serial) identities over 16
// slots. An operation is accepted every cycle while in_stall is low; its result passes
// the input register, then the result register. The lowest-free-slot search is a
// priority encoder over per-slot occupancy flip-flops, so there is no iteration and reset
// needs no clearing pass. The user writes active_slots through the cfg port only while
// idle, which the block does not enforce; depends on ght_pkg and ght_table
module generational_handle_table_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ght_pkg::MODE_W-1:0]         mode,
    input  logic [ght_pkg::SLOT_W-1:0]         slot_in,
    input  logic [ght_pkg::SERIAL_W-1:0]       serial_in,
    input  logic [ght_pkg::PAYLOAD_BITS-1:0]   payload_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               ok,
    output logic [ght_pkg::SLOT_W-1:0]         slot_out,
    output logic [ght_pkg::SERIAL_W-1:0]       serial_out,
    output logic [ght_pkg::PAYLOAD_BITS-1:0]   payload_out,
    output logic [ght_pkg::COUNT_W-1:0]        used_count,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ght_pkg::COUNT_W-1:0]        cfg_data
);
    import ght_pkg::*;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    op_t                s1_op_reg;
    op_t                s1_op_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               out_res_reg;
    res_t               out_res_next;
    logic [COUNT_W-1:0] active_reg;
    logic [COUNT_W-1:0] active_next;

    logic               advance;
    logic               commit;
    logic               in_beat;
    op_t                in_op;
    res_t               res;

    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign commit    = s1_valid_reg && advance;
    assign in_beat   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign in_op.mode    = mode;
    assign in_op.slot    = slot_in;
    assign in_op.serial  = serial_in;
    assign in_op.payload = payload_in;

    ght_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .op     (s1_op_reg),
        .active (active_reg),
        .res    (res)
    );

    always_comb
    begin
        s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
        s1_op_next     = in_beat ? in_op : s1_op_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
        out_res_next   = commit ? res : out_res_reg;
        active_next    = cfg_valid ? cfg_data : active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= COUNT_W'(SLOTS);
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= s1_op_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign ok          = out_res_reg.ok;
    assign slot_out    = out_res_reg.slot;
    assign serial_out  = out_res_reg.serial;
    assign payload_out = out_res_reg.payload;
    assign used_count  = out_res_reg.used;

    a_serial_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && serial_out != '0) |-> ok)
        else $error("nonzero serial on a failed result");

    a_payload_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && payload_out != '0) |-> (ok && serial_out == '0))
        else $error("payload returned outside a live lookup");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (used_count <= COUNT_W'(SLOTS)))
        else $error("used count above slot count");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

endmodule

>>> verif/handle_table_check.sv
// result checker for generational_handle_table_top: keeps its own slot table, predicts one
// result beat per accepted operation and compares the returned beats in order
// depends on ght_pkg
module handle_table_check
    import ght_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [MODE_W-1:0]       mode,
    input  logic [SLOT_W-1:0]       slot_in,
    input  logic [SERIAL_W-1:0]     serial_in,
    input  logic [PAYLOAD_BITS-1:0] payload_in,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic                    ok,
    input  logic [SLOT_W-1:0]       slot_out,
    input  logic [SERIAL_W-1:0]     serial_out,
    input  logic [PAYLOAD_BITS-1:0] payload_out,
    input  logic [COUNT_W-1:0]      used_count,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [COUNT_W-1:0]      cfg_data,
    output int unsigned             pending,
    output int unsigned             errors
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PAYLOAD_BITS-1:0] tag_mem [SLOTS];
    logic [SERIAL_W-1:0]     serial_mem [SLOTS];
    logic [SERIAL_W-1:0]     serial_next;
    logic [COUNT_W-1:0]      used_now;
    logic [COUNT_W-1:0]      active_now;
    res_t                    awaited [$];
    int unsigned             fail_count = 0;

    assign errors = fail_count;

    // register values above the table size behave as the full table
    function automatic int usable_slots();
        return (active_now > SLOTS) ? SLOTS : int'(active_now);
    endfunction

    function automatic bit identity_live(logic [SLOT_W-1:0] s, logic [SERIAL_W-1:0] n);
        return n != '0 && int'(s) < usable_slots() && serial_mem[s] == n && tag_mem[s] != '0;
    endfunction

    function automatic res_t apply_op(op_t op);
        res_t r;
        bit   placed;
        r = '0;
        placed = 1'b0;
        case (op.mode)
            MODE_MINT:
            begin
                if (op.payload != '0)
                begin
                    for (int i = 0; i < usable_slots(); i++)
                    begin
                        if (!placed && tag_mem[i] == '0)
                        begin
                            tag_mem[i]    = op.payload;
                            serial_mem[i] = serial_next;
                            r.ok          = 1'b1;
                            r.slot        = SLOT_W'(i);
                            r.serial      = serial_next;
                            serial_next   = serial_next + 1'b1;
                            if (serial_next == '0)
                                serial_next = 1;
                            used_now      = used_now + 1'b1;
                            placed        = 1'b1;
                        end
                    end
                end
            end
            MODE_RELEASE:
            begin
                if (identity_live(op.slot, op.serial))
                begin
                    tag_mem[op.slot]    = '0;
                    serial_mem[op.slot] = '0;
                    used_now            = used_now - 1'b1;
                    r.ok                = 1'b1;
                end
            end
            MODE_LOOKUP:
            begin
                if (identity_live(op.slot, op.serial))
                begin
                    r.ok      = 1'b1;
                    r.payload = tag_mem[op.slot];
                end
            end
            default:
            begin
            end
        endcase
        r.used = used_now;
        return r;
    endfunction

    task automatic check_field(string name, logic [SERIAL_W-1:0] want,
                               logic [SERIAL_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        op_t  op;
        res_t seen;
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                tag_mem[i]    = '0;
                serial_mem[i] = '0;
            end
            serial_next = 1;
            used_now    = '0;
            active_now  = COUNT_W'(SLOTS);
            awaited.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                active_now = cfg_data;
            if (in_valid && !in_stall)
            begin
                op = {mode, slot_in, serial_in, payload_in};
                awaited.push_back(apply_op(op));
            end
            if (out_valid && !out_stall)
            begin
                seen = {ok, slot_out, serial_out, payload_out, used_count};
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat expected none got %0h", $time, seen);
                end
                else
                begin
                    want = awaited.pop_front();
                    check_field("ok", want.ok, seen.ok);
                    check_field("slot_out", want.slot, seen.slot);
                    check_field("serial_out", want.serial, seen.serial);
                    check_field("payload_out", want.payload, seen.payload);
                    check_field("used_count", want.used, seen.used);
                end
            end
            pending <= awaited.size();
        end
    end

endmodule

>>> verif/tb.sv
// top of the generational handle table testbench: clock, reset, operation and register
// stimulus with random idling; depends on ght_pkg, generational_handle_table_top and
// handle_table_check, which does all the predicting and comparing
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ght_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 6;
    localparam int PHASES      = 7;
    localparam logic [SERIAL_W-1:0] ALL_SERIAL = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [SERIAL_W-1:0] serial;
    } ident_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_stall;
    logic [MODE_W-1:0]       mode       = '0;
    logic [SLOT_W-1:0]       slot_in    = '0;
    logic [SERIAL_W-1:0]     serial_in  = '0;
    logic [PAYLOAD_BITS-1:0] payload_in = '0;
    logic                    out_valid;
    logic                    out_stall  = 1'b0;
    logic                    ok;
    logic [SLOT_W-1:0]       slot_out;
    logic [SERIAL_W-1:0]     serial_out;
    logic [PAYLOAD_BITS-1:0] payload_out;
    logic [COUNT_W-1:0]      used_count;
    logic                    cfg_valid  = 1'b0;
    logic                    cfg_ready;
    logic [COUNT_W-1:0]      cfg_data   = '0;
    int unsigned             pending;
    int unsigned             errors;

    ident_t      minted [$];
    bit          idle_on  = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned cycles   = 0;

    int                 phase_items  [PHASES] = '{100, 90, 60, 90, 30, 90, 110};
    logic [COUNT_W-1:0] phase_active [PHASES] = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd9, 5'd16};

    generational_handle_table_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .slot_in     (slot_in),
        .serial_in   (serial_in),
        .payload_in  (payload_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .slot_out    (slot_out),
        .serial_out  (serial_out),
        .payload_out (payload_out),
        .used_count  (used_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    handle_table_check check_u (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .slot_in     (slot_in),
        .serial_in   (serial_in),
        .payload_in  (payload_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .slot_out    (slot_out),
        .serial_out  (serial_out),
        .payload_out (payload_out),
        .used_count  (used_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .pending     (pending),
        .errors      (errors)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // identities handed out by the block, reused for release and lookup beats
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall && ok && serial_out != '0)
        begin
            minted.push_back('{slot_out, serial_out});
            if (minted.size() > 24)
                void'(minted.pop_front());
        end
    end

    // result side back-pressure
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    task automatic offer(op_t op);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op.mode;
        slot_in    <= op.slot;
        serial_in  <= op.serial;
        payload_in <= op.payload;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic set_active(logic [COUNT_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly real identities, some damaged ones and some pure noise
    function automatic op_t random_op();
        op_t    op;
        ident_t id;
        int     pick;
        int     idx;
        op.slot    = SLOT_W'($urandom);
        op.serial  = {$urandom, $urandom};
        op.payload = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 36)
        begin
            op.mode = MODE_MINT;
            case ($urandom_range(0, 19))
                0: op.payload = '0;
                1: op.payload = '1;
                default: if (op.payload == '0) op.payload = 1;
            endcase
        end
        else if (pick < 96)
        begin
            op.mode = (pick < 66) ? MODE_RELEASE : MODE_LOOKUP;
            pick = $urandom_range(0, 19);
            idx  = 0;
            if (minted.size() != 0)
            begin
                idx = $urandom_range(0, minted.size() - 1);
                id  = minted[idx];
            end
            else
                pick = 19;
            if (pick < 14)
            begin
                op.slot   = id.slot;
                op.serial = id.serial;
                if (op.mode == MODE_RELEASE && pick < 12)
                    minted.delete(idx);
            end
            else if (pick == 14)
            begin
                op.slot   = id.slot;
                op.serial = id.serial ^ (64'd1 << $urandom_range(0, 63));
            end
            else if (pick == 15)
            begin
                op.slot   = SLOT_W'(id.slot + $urandom_range(1, 15));
                op.serial = id.serial;
            end
            else if (pick == 16)
                op.serial = '0;
            else if (pick < 19)
                op.serial = SERIAL_W'($urandom_range(1, 64));
        end
        else
            op.mode = MODE_NOP;
        return op;
    endfunction

    initial
    begin
        op_t op;
        int  done;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer({MODE_MINT, 4'd0, 64'd0, 32'd0});
        offer({MODE_MINT, 4'hF, ALL_SERIAL, 32'hFFFF_FFFF});
        offer({MODE_MINT, 4'd0, 64'd0, 32'd1});
        offer({MODE_LOOKUP, 4'd0, 64'd1, 32'd0});
        offer({MODE_LOOKUP, 4'd0, 64'd0, 32'd0});
        offer({MODE_LOOKUP, 4'd1, 64'd1, 32'd0});
        offer({MODE_LOOKUP, 4'hF, ALL_SERIAL, 32'hFFFF_FFFF});
        offer({MODE_RELEASE, 4'd0, 64'd2, 32'd0});
        offer({MODE_RELEASE, 4'd0, 64'd1, 32'd0});
        offer({MODE_LOOKUP, 4'd0, 64'd1, 32'd0});
        offer({MODE_RELEASE, 4'd0, 64'd1, 32'd0});
        offer({MODE_NOP, 4'hF, ALL_SERIAL, 32'hFFFF_FFFF});
        offer({MODE_MINT, 4'd0, 64'd0, 32'hA5A5_5A5A});
        offer({MODE_LOOKUP, 4'd1, 64'd2, 32'd0});
        // two usable slots, both taken
        set_active(5'd2);
        offer({MODE_MINT, 4'd0, 64'd0, 32'h1234_5678});
        offer({MODE_RELEASE, 4'd1, 64'd2, 32'd0});
        offer({MODE_MINT, 4'd0, 64'd0, 32'h8000_0000});
        // slot 1 stays occupied but out of reach
        set_active(5'd1);
        offer({MODE_LOOKUP, 4'd1, 64'd4, 32'd0});
        offer({MODE_RELEASE, 4'd1, 64'd4, 32'd0});
        offer({MODE_MINT, 4'd0, 64'd0, 32'h0000_0077});
        set_active(5'd0);
        offer({MODE_LOOKUP, 4'd0, 64'd3, 32'd0});
        offer({MODE_MINT, 4'd0, 64'd0, 32'h0000_0055});
        set_active(5'd31);
        offer({MODE_LOOKUP, 4'd1, 64'd4, 32'd0});
        offer({MODE_MINT, 4'd0, 64'd0, 32'h0000_00AA});

        for (int p = 0; p < PHASES; p++)
        begin
            set_active(phase_active[p]);
            idle_on = (p != PHASES - 1);
            if (p == 3)
                hold_req = 1'b1;
            done = 0;
            while (done < phase_items[p])
            begin
                op = random_op();
                offer(op);
                if (op.mode != MODE_NOP)
                    done++;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
